// ----- hdl/crb_pkg.sv -----
// Shared constants, register codes and data types for the replicate-border convolution block.
package crb_pkg;

    // Default sizes for the top level parameters.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_KERNEL = 5;
    localparam int DEF_NUM_SLOTS  = 6;

    // Field and register widths.
    localparam int PIX_W       = 8;
    localparam int COEF_W      = 12;
    localparam int COEF_ROWS   = 5;
    localparam int COEF_SEL_W  = 3;
    localparam int COEF_ROW_W  = 60;
    localparam int ROW_W       = 16;
    localparam int OUT_COL_W   = 10;
    localparam int VALUE_W     = 25;
    localparam int PROD_W      = 21;
    localparam int RSUM_W      = 24;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 60;
    localparam int IMG_W_W     = 11;
    localparam int WCMP_W      = 13;
    localparam int RAD_W       = 2;

    // The line store is split into column banks so that five neighbouring columns
    // always fall into different banks.
    localparam int NUM_BANKS   = 8;
    localparam int BANK_W      = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 8'd0,
        REG_IMAGE_HEIGHT  = 8'd1,
        REG_KERNEL_RADIUS = 8'd2,
        REG_COEF_ROW0     = 8'd3,
        REG_COEF_ROW1     = 8'd4,
        REG_COEF_ROW2     = 8'd5,
        REG_COEF_ROW3     = 8'd6,
        REG_COEF_ROW4     = 8'd7
    } cfg_reg_t;

    // Input operation codes.
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef logic [PIX_W-1:0]              pix_t;
    typedef logic [BANK_W-1:0]             bank_t;
    typedef logic [ROW_W-1:0]              row_t;
    typedef logic [ROW_W:0]                rowx_t;
    typedef logic [OUT_COL_W-1:0]          out_col_t;
    typedef logic [COEF_ROW_W-1:0]         coef_row_t;
    typedef logic [COEF_SEL_W-1:0]         coef_sel_t;
    typedef logic [RAD_W-1:0]              rad_t;
    typedef logic [WCMP_W-1:0]             wcmp_t;
    typedef logic signed [COEF_W-1:0]      coef_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [RSUM_W-1:0]      rsum_t;
    typedef logic signed [VALUE_W-1:0]     value_t;

endpackage

// ----- hdl/conv2d_replicate_border.sv -----
// Top level of the streaming 2D convolution with replicate borders.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     operation, pixel
//   result    out_valid / out_ready   value, out_row, out_col, frame_end
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One item is accepted per clock while the pipeline is not stalled by out_ready.
// The rate is set by the banked line store, which delivers a full window column set per read.
// Reset clears the counters and loads the register defaults; the line store needs no clearing.
// A stalled result holds only the stages that are full, so bubbles still take new items.
module conv2d_replicate_border #(
    parameter int MAX_WIDTH  = crb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = crb_pkg::DEF_MAX_KERNEL
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                operation,
    input  logic [crb_pkg::PIX_W-1:0]           pixel,
    // Results
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [crb_pkg::VALUE_W-1:0]  value,
    output logic [crb_pkg::ROW_W-1:0]           out_row,
    output logic [crb_pkg::OUT_COL_W-1:0]       out_col,
    output logic                                frame_end,
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [crb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [crb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int RM        = (MAX_KERNEL - 1) / 2;
    localparam int KT        = 2 * RM + 1;
    localparam int NS        = 2 * RM + 2;
    localparam int SLOT_W    = $clog2(NS);
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int BANK_ROWS = (MAX_WIDTH + crb_pkg::NUM_BANKS - 1) / crb_pkg::NUM_BANKS;
    localparam int BA_W      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
    localparam int W_RST     = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int R_RST     = (RM < 1) ? RM : 1;

    typedef logic [COL_W-1:0]  col_t;
    typedef logic [COL_W:0]    colx_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [BA_W-1:0]   ba_t;

    // ------------------------------------------------------------------
    // Configuration registers, held in their effective (saturated) form.
    // ------------------------------------------------------------------
    col_t                   w_m1_reg;
    crb_pkg::row_t          h_m1_reg;
    crb_pkg::rad_t          r_reg;
    crb_pkg::coef_row_t     coef_reg [crb_pkg::COEF_ROWS];

    logic                   cfg_fire;
    logic                   cfg_hit;
    col_t                   w_m1_new;
    crb_pkg::row_t          h_m1_new;
    crb_pkg::rad_t          r_new;
    crb_pkg::coef_sel_t     coef_sel;
    crb_pkg::wcmp_t         wv;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Saturate the written values and decode which writes restart the frame.
    always_comb
    begin
        wv       = crb_pkg::wcmp_t'(cfg_data[crb_pkg::IMG_W_W-1:0]);
        w_m1_new = '0;
        if (wv > crb_pkg::wcmp_t'(MAX_WIDTH))
        begin
            w_m1_new = col_t'(MAX_WIDTH - 1);
        end
        else if (wv != '0)
        begin
            w_m1_new = col_t'(wv - crb_pkg::wcmp_t'(1));
        end
        h_m1_new = (cfg_data[crb_pkg::ROW_W-1:0] == '0) ? '0
                 : cfg_data[crb_pkg::ROW_W-1:0] - crb_pkg::row_t'(1);
        r_new    = (cfg_data[crb_pkg::RAD_W-1:0] > crb_pkg::rad_t'(RM)) ? crb_pkg::rad_t'(RM)
                 : cfg_data[crb_pkg::RAD_W-1:0];
        coef_sel = crb_pkg::coef_sel_t'(cfg_index - crb_pkg::REG_COEF_ROW0);
        cfg_hit  = cfg_fire && (cfg_index <= crb_pkg::REG_COEF_ROW4);
    end

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_m1_reg <= col_t'(W_RST - 1);
            h_m1_reg <= '0;
            r_reg    <= crb_pkg::rad_t'(R_RST);
            for (int i = 0; i < crb_pkg::COEF_ROWS; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_fire)
        begin
            unique case (cfg_index) inside
                crb_pkg::REG_IMAGE_WIDTH:   w_m1_reg <= w_m1_new;
                crb_pkg::REG_IMAGE_HEIGHT:  h_m1_reg <= h_m1_new;
                crb_pkg::REG_KERNEL_RADIUS: r_reg    <= r_new;
                crb_pkg::REG_COEF_ROW0, crb_pkg::REG_COEF_ROW1, crb_pkg::REG_COEF_ROW2,
                crb_pkg::REG_COEF_ROW3, crb_pkg::REG_COEF_ROW4:
                    coef_reg[coef_sel] <= cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: each stage moves when it is empty or the next one moves.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic en1, en2, en3, en4;
    logic fire;

    assign en4      = !out_valid_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;
    assign fire     = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Input and output position counters.
    // ------------------------------------------------------------------
    crb_pkg::row_t  in_row_reg,  in_row_next,  in_row_w;
    col_t           in_col_reg,  in_col_next,  in_col_w;
    slot_t          in_slot_reg, in_slot_next, in_slot_w;
    logic           done_reg,    done_next,    done_w;
    crb_pkg::row_t  out_row_reg, out_row_next;
    col_t           out_col_reg, out_col_next;
    slot_t          out_slot_reg, out_slot_next;

    logic           wr_fire;
    logic           emit;
    logic           last;
    logic           rdy;
    crb_pkg::rowx_t need_rx;
    colx_t          need_cx;
    crb_pkg::row_t  need_r;
    col_t           need_c;

    // Store the pixel, then decide whether the next result can be formed.
    always_comb
    begin
        wr_fire   = fire && (operation == crb_pkg::OP_PIXEL) && !done_reg;
        in_row_w  = in_row_reg;
        in_col_w  = in_col_reg;
        in_slot_w = in_slot_reg;
        done_w    = done_reg;
        if (wr_fire)
        begin
            if (in_col_reg == w_m1_reg)
            begin
                in_col_w = '0;
                if (in_row_reg == h_m1_reg)
                begin
                    in_row_w  = '0;
                    in_slot_w = '0;
                    done_w    = 1'b1;
                end
                else
                begin
                    in_row_w  = in_row_reg + crb_pkg::row_t'(1);
                    in_slot_w = (in_slot_reg == slot_t'(NS - 1)) ? '0
                              : in_slot_reg + slot_t'(1);
                end
            end
            else
            begin
                in_col_w = in_col_reg + col_t'(1);
            end
        end

        // The bottom-right pixel of the window must already be in store.
        need_rx = crb_pkg::rowx_t'(out_row_reg) + crb_pkg::rowx_t'(r_reg);
        need_cx = colx_t'(out_col_reg) + colx_t'(r_reg);
        need_r  = (need_rx > crb_pkg::rowx_t'(h_m1_reg)) ? h_m1_reg
                : need_rx[crb_pkg::ROW_W-1:0];
        need_c  = (need_cx > colx_t'(w_m1_reg)) ? w_m1_reg : need_cx[COL_W-1:0];
        rdy     = done_w || (need_r < in_row_w) || ((need_r == in_row_w) && (need_c < in_col_w));
        emit    = fire && rdy;
        last    = (out_row_reg == h_m1_reg) && (out_col_reg == w_m1_reg);

        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_slot_next = out_slot_reg;
        done_next     = done_w;
        if (emit)
        begin
            if (last)
            begin
                out_row_next  = '0;
                out_col_next  = '0;
                out_slot_next = '0;
                done_next     = 1'b0;
            end
            else if (out_col_reg == w_m1_reg)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + crb_pkg::row_t'(1);
                out_slot_next = (out_slot_reg == slot_t'(NS - 1)) ? '0
                              : out_slot_reg + slot_t'(1);
            end
            else
            begin
                out_col_next = out_col_reg + col_t'(1);
            end
        end
        in_row_next  = in_row_w;
        in_col_next  = in_col_w;
        in_slot_next = in_slot_w;
    end

    // Counter registers; a register write abandons the frame in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            done_reg     <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else if (cfg_hit)
        begin
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_slot_reg  <= '0;
            done_reg     <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_slot_reg <= '0;
        end
        else if (fire)
        begin
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_slot_reg  <= in_slot_next;
            done_reg     <= done_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_slot_reg <= out_slot_next;
        end
    end

    // ------------------------------------------------------------------
    // Window addressing: clamped row slots, column banks and bank addresses.
    // ------------------------------------------------------------------
    slot_t          row_slot_d [KT];
    crb_pkg::bank_t bank_d     [KT];
    ba_t            rd_addr    [crb_pkg::NUM_BANKS];

    always_comb
    begin
        int off;
        int span;
        int idx;
        int lo;
        int c;
        for (int t = 0; t < KT; t++)
        begin
            // Row offset, clamped to the frame.
            off  = t - RM;
            span = int'(h_m1_reg) - int'(out_row_reg);
            if ((off < 0) && (int'(out_row_reg) < -off))
            begin
                off = -int'(out_row_reg);
            end
            else if ((off > 0) && (span < off))
            begin
                off = span;
            end
            idx = int'(out_slot_reg) + off;
            if (idx < 0)
            begin
                idx = idx + NS;
            end
            else if (idx >= NS)
            begin
                idx = idx - NS;
            end
            row_slot_d[t] = slot_t'(idx);

            // Column offset, clamped to the row.
            off  = t - RM;
            span = int'(w_m1_reg) - int'(out_col_reg);
            if ((off < 0) && (int'(out_col_reg) < -off))
            begin
                off = -int'(out_col_reg);
            end
            else if ((off > 0) && (span < off))
            begin
                off = span;
            end
            bank_d[t] = crb_pkg::bank_t'(int'(out_col_reg) + off);
        end

        // Each bank holds at most one column of the window span.
        lo = (int'(out_col_reg) >= RM) ? int'(out_col_reg) - RM : 0;
        for (int b = 0; b < crb_pkg::NUM_BANKS; b++)
        begin
            c          = lo + ((b - lo) & (crb_pkg::NUM_BANKS - 1));
            rd_addr[b] = ba_t'(c >> crb_pkg::BANK_W);
        end
    end

    crb_pkg::pix_t rd_data [NS][crb_pkg::NUM_BANKS];

    crb_line_store #(
        .MAX_WIDTH (MAX_WIDTH),
        .NUM_SLOTS (NS)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (wr_fire),
        .wr_slot (in_slot_reg),
        .wr_bank (crb_pkg::bank_t'(in_col_reg)),
        .wr_addr (ba_t'(in_col_reg >> crb_pkg::BANK_W)),
        .wr_data (pixel),
        .rd_en   (en1),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: window selects and position alongside the store read.
    // ------------------------------------------------------------------
    slot_t          row_slot_s1_reg [KT];
    crb_pkg::bank_t bank_s1_reg     [KT];
    crb_pkg::row_t  row_s1_reg, row_s2_reg, row_s3_reg, row_s4_reg;
    col_t           col_s1_reg, col_s2_reg, col_s3_reg, col_s4_reg;
    logic           last_s1_reg, last_s2_reg, last_s3_reg, last_s4_reg;

    // Stage 2: tap products.
    crb_pkg::prod_t prod_d     [KT][KT];
    crb_pkg::prod_t prod_s2_reg[KT][KT];

    // Stage 3: row sums.
    crb_pkg::rsum_t rsum_d     [KT];
    crb_pkg::rsum_t rsum_s3_reg[KT];

    // Stage 4: the result.
    crb_pkg::value_t value_d;
    crb_pkg::value_t value_reg;

    // Select each tap and weight it with the flipped kernel coefficient.
    always_comb
    begin
        int            e;
        int            d;
        int            r;
        int            ci;
        int            cj;
        logic          on;
        crb_pkg::pix_t px;
        crb_pkg::coef_t cf;
        r = int'(r_reg);
        for (int t = 0; t < KT; t++)
        begin
            for (int u = 0; u < KT; u++)
            begin
                e  = t - RM;
                d  = u - RM;
                on = (e <= r) && (-e <= r) && (d <= r) && (-d <= r);
                ci = on ? r - e : 0;
                cj = on ? r - d : 0;
                cf = crb_pkg::coef_t'(
                         coef_reg[crb_pkg::coef_sel_t'(ci)][cj*crb_pkg::COEF_W +: crb_pkg::COEF_W]);
                px = rd_data[row_slot_s1_reg[t]][bank_s1_reg[u]];
                prod_d[t][u] = on ? crb_pkg::prod_t'(signed'({1'b0, px})) * crb_pkg::prod_t'(cf)
                             : '0;
            end
        end
    end

    // Sum each window row.
    always_comb
    begin
        for (int t = 0; t < KT; t++)
        begin
            rsum_d[t] = '0;
            for (int u = 0; u < KT; u++)
            begin
                rsum_d[t] = rsum_d[t] + crb_pkg::rsum_t'(prod_s2_reg[t][u]);
            end
        end
    end

    // Sum the row sums.
    always_comb
    begin
        value_d = '0;
        for (int t = 0; t < KT; t++)
        begin
            value_d = value_d + crb_pkg::value_t'(rsum_s3_reg[t]);
        end
    end

    // Stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= emit;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                out_valid_reg <= v3_reg;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            row_slot_s1_reg <= row_slot_d;
            bank_s1_reg     <= bank_d;
            row_s1_reg      <= out_row_reg;
            col_s1_reg      <= out_col_reg;
            last_s1_reg     <= last;
        end
        if (en2)
        begin
            prod_s2_reg <= prod_d;
            row_s2_reg  <= row_s1_reg;
            col_s2_reg  <= col_s1_reg;
            last_s2_reg <= last_s1_reg;
        end
        if (en3)
        begin
            rsum_s3_reg <= rsum_d;
            row_s3_reg  <= row_s2_reg;
            col_s3_reg  <= col_s2_reg;
            last_s3_reg <= last_s2_reg;
        end
        if (en4)
        begin
            value_reg   <= value_d;
            row_s4_reg  <= row_s3_reg;
            col_s4_reg  <= col_s3_reg;
            last_s4_reg <= last_s3_reg;
        end
    end

    // Result port.
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_row   = row_s4_reg;
    assign out_col   = crb_pkg::out_col_t'(col_s4_reg);
    assign frame_end = last_s4_reg;

endmodule

// ----- hdl/crb_line_store.sv -----
// Banked ring of line stores: one bank array per row slot and column bank, write-first reads.
module crb_line_store #(
    parameter int MAX_WIDTH = crb_pkg::DEF_MAX_WIDTH,
    parameter int NUM_SLOTS = crb_pkg::DEF_NUM_SLOTS,
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
    localparam int BANK_ROWS = (MAX_WIDTH + crb_pkg::NUM_BANKS - 1) / crb_pkg::NUM_BANKS,
    localparam int BA_W      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [SLOT_W-1:0]   wr_slot,
    input  crb_pkg::bank_t      wr_bank,
    input  logic [BA_W-1:0]     wr_addr,
    input  crb_pkg::pix_t       wr_data,
    input  logic                rd_en,
    input  logic [BA_W-1:0]     rd_addr [crb_pkg::NUM_BANKS],
    output crb_pkg::pix_t       rd_data [NUM_SLOTS][crb_pkg::NUM_BANKS]
);

    localparam int BANK_DEPTH = 2 ** BA_W;

    typedef logic [SLOT_W-1:0] slot_t;

    for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
        for (genvar b = 0; b < crb_pkg::NUM_BANKS; b++) begin : g_bank
            crb_pkg::pix_t mem [BANK_DEPTH];
            crb_pkg::pix_t q_reg;
            logic          hit;

            // This bank takes the pixel when both the row slot and the column bank match.
            assign hit = wr_en && (wr_slot == slot_t'(s)) && (wr_bank == crb_pkg::bank_t'(b));

            // A read of the address being written returns the new pixel.
            always_ff @(posedge clk)
            begin
                if (hit)
                begin
                    mem[wr_addr] <= wr_data;
                end
                if (rd_en)
                begin
                    if (hit && (wr_addr == rd_addr[b]))
                    begin
                        q_reg <= wr_data;
                    end
                    else
                    begin
                        q_reg <= mem[rd_addr[b]];
                    end
                end
            end

            assign rd_data[s][b] = q_reg;
        end
    end

endmodule
